@@ design/hdvp_pkg.sv @@
// shared types and constants for the heater duty and valve pulse controller
`timescale 1ns / 1ps
`default_nettype none
package hdvp_pkg;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_MEASURE     = 2'd1,
    OP_VALVE_OPEN  = 2'd2,
    OP_VALVE_CLOSE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_DUTY_LOW  = 2'd0,
    REG_DUTY_HIGH = 2'd1,
    REG_ZONE      = 2'd2,
    REG_CRITICAL  = 2'd3
  } reg_idx_t;

  localparam logic [7:0] MIN_VALID_READING = 8'h10;
  localparam logic [7:0] STALE_LIMIT       = 8'd100;
  localparam logic [7:0] STALE_MAX         = 8'd254;
  localparam logic [7:0] DUTY_ALWAYS       = 8'd255;
  localparam logic [7:0] READING_RESET     = 8'd255;

  typedef struct packed {
    logic       heater_drive;
    logic       valve_open_drive;
    logic       valve_close_drive;
    logic [7:0] temperature_reading;
    logic [7:0] stale_count;
    logic [7:0] duty_phase;
  } res_t;

endpackage
`default_nettype wire

@@ design/hdvp_obuf.sv @@
// two-entry result buffer: output register plus skid register
`timescale 1ns / 1ps
`default_nettype none
module hdvp_obuf
  import hdvp_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  wire  out_stall,
  output res_t out_data
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_data_r, out_data_nxt;
  res_t skid_data_r, skid_data_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      // output held by the receiver, park the new item
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ design/heater_duty_and_valve_pulse_ctrl.sv @@
// top level: heater duty decision, measurement store and valve pulse timer
//
// input channel (in_valid / in_stall) carries one item per handshake: a tick,
// a temperature measurement, a valve open or a valve close command.
// every accepted item yields exactly one result item on the out_ channel,
// showing heater and coil drives, the stored reading, the stale count and
// the phase counter as they stand after that item.
// the result is registered in the output register, or in the skid register
// while the receiver stalls. throughput: one item per cycle while in_stall
// is low; the state update and result forming are one pass of compares and counters.
// the result channel has an output register and a skid register; in_stall
// rises only when both hold items, i.e. the receiver has stalled for two
// items, and drops the cycle after the receiver takes one.
// configuration: cfg_valid / cfg_ready with cfg_index and cfg_data, always
// ready; write only while no item is in flight.
// reset (rst_n low, synchronous): registers to 0, stored reading to 255,
// valve timer reloaded, coils and heater off, both result entries emptied.
`timescale 1ns / 1ps
`default_nettype none
module heater_duty_and_valve_pulse_ctrl
  import hdvp_pkg::*;
#(
  parameter int COARSE_PULSES = 100,
  parameter int FINE_PULSES   = 20
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [1:0] in_op,
  input  wire  [7:0] in_reading,
  input  wire        in_reading_overflow,
  input  wire        in_reading_disturbed,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_heater_drive,
  output logic       out_valve_open_drive,
  output logic       out_valve_close_drive,
  output logic [7:0] out_temperature_reading,
  output logic [7:0] out_stale_count,
  output logic [7:0] out_duty_phase,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [1:0] cfg_index,
  input  wire  [7:0] cfg_data
);

  localparam int CW = $clog2(COARSE_PULSES + 1);
  localparam int FW = $clog2(FINE_PULSES + 1);
  localparam logic [CW-1:0] COARSE_RELOAD = CW'(COARSE_PULSES);
  localparam logic [FW-1:0] FINE_RELOAD   = FW'(FINE_PULSES);

  logic [7:0] duty_low_r, duty_high_r, zone_r, critical_r;

  logic [7:0]    reading_r, reading_nxt;
  logic [7:0]    stale_r, stale_nxt;
  logic [7:0]    phase_r, phase_nxt;
  logic          heater_r, heater_nxt;
  logic          open_r, open_nxt;
  logic          close_r, close_nxt;
  logic          pulse_r, pulse_nxt;
  logic [CW-1:0] coarse_r, coarse_nxt;
  logic [FW-1:0] fine_r, fine_nxt;

  logic       in_acc;
  logic       buf_full;
  logic       heater_dec;
  logic [7:0] duty_sel;
  op_t        op;
  res_t       res, out_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_acc    = in_valid && !buf_full;
  assign op        = op_t'(in_op);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_low_r  <= '0;
      duty_high_r <= '0;
      zone_r      <= '0;
      critical_r  <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DUTY_LOW:  duty_low_r  <= cfg_data;
        REG_DUTY_HIGH: duty_high_r <= cfg_data;
        REG_ZONE:      zone_r      <= cfg_data;
        REG_CRITICAL:  critical_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // heater decision from the stored reading and the phase before increment
  always_comb begin
    duty_sel = (reading_r <= zone_r) ? duty_high_r : duty_low_r;
    if (reading_r < MIN_VALID_READING || stale_r > STALE_LIMIT) begin
      heater_dec = 1'b0;
    end else if (reading_r <= critical_r) begin
      heater_dec = 1'b0;
    end else if (duty_sel == DUTY_ALWAYS) begin
      heater_dec = 1'b1;
    end else begin
      heater_dec = phase_r < duty_sel;
    end
  end

  always_comb begin
    reading_nxt = reading_r;
    stale_nxt   = stale_r;
    phase_nxt   = phase_r;
    heater_nxt  = heater_r;
    open_nxt    = open_r;
    close_nxt   = close_r;
    pulse_nxt   = pulse_r;
    coarse_nxt  = coarse_r;
    fine_nxt    = fine_r;
    if (in_acc) begin
      unique case (op)
        OP_TICK: begin
          heater_nxt = heater_dec;
          phase_nxt  = phase_r + 8'd1;
          if (pulse_r) begin
            if (fine_r == '0) begin
              if (coarse_r == '0) begin
                open_nxt  = 1'b0;
                close_nxt = 1'b0;
                pulse_nxt = 1'b0;
              end else begin
                coarse_nxt = coarse_r - CW'(1);
                fine_nxt   = FINE_RELOAD;
              end
            end else begin
              fine_nxt = fine_r - FW'(1);
            end
          end
        end
        OP_MEASURE: begin
          if (in_reading_disturbed) begin
            if (stale_r < STALE_MAX) stale_nxt = stale_r + 8'd1;
          end else begin
            reading_nxt = in_reading_overflow ? READING_RESET : in_reading;
            stale_nxt   = '0;
          end
        end
        OP_VALVE_OPEN, OP_VALVE_CLOSE: begin
          open_nxt   = (op == OP_VALVE_OPEN);
          close_nxt  = (op == OP_VALVE_CLOSE);
          coarse_nxt = COARSE_RELOAD;
          fine_nxt   = FINE_RELOAD;
          pulse_nxt  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reading_r <= READING_RESET;
      stale_r   <= '0;
      phase_r   <= '0;
      heater_r  <= 1'b0;
      open_r    <= 1'b0;
      close_r   <= 1'b0;
      pulse_r   <= 1'b0;
      coarse_r  <= COARSE_RELOAD;
      fine_r    <= FINE_RELOAD;
    end else begin
      reading_r <= reading_nxt;
      stale_r   <= stale_nxt;
      phase_r   <= phase_nxt;
      heater_r  <= heater_nxt;
      open_r    <= open_nxt;
      close_r   <= close_nxt;
      pulse_r   <= pulse_nxt;
      coarse_r  <= coarse_nxt;
      fine_r    <= fine_nxt;
    end
  end

  always_comb begin
    res.heater_drive        = heater_nxt;
    res.valve_open_drive    = open_nxt;
    res.valve_close_drive   = close_nxt;
    res.temperature_reading = reading_nxt;
    res.stale_count         = stale_nxt;
    res.duty_phase          = phase_nxt;
  end

  hdvp_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_heater_drive        = out_res.heater_drive;
  assign out_valve_open_drive    = out_res.valve_open_drive;
  assign out_valve_close_drive   = out_res.valve_close_drive;
  assign out_temperature_reading = out_res.temperature_reading;
  assign out_stale_count         = out_res.stale_count;
  assign out_duty_phase          = out_res.duty_phase;

endmodule
`default_nettype wire

@@ design/hdvp_checker.sv @@
// port-level checks for the heater duty and valve pulse controller
`timescale 1ns / 1ps
`default_nettype none
module hdvp_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire       out_heater_drive,
  input wire       out_valve_open_drive,
  input wire       out_valve_close_drive,
  input wire [7:0] out_temperature_reading,
  input wire [7:0] out_stale_count,
  input wire [7:0] out_duty_phase
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty_phase)
      && $stable(out_stale_count) && $stable(out_temperature_reading)
      && $stable(out_heater_drive) && $stable(out_valve_open_drive)
      && $stable(out_valve_close_drive))
    else $error("stalled result changed");

  a_coils: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_valve_open_drive && out_valve_close_drive))
    else $error("both valve coils driven");

  a_stale_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stale_count != 8'hff)
    else $error("stale count past saturation");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |=> !in_stall)
    else $error("input stalled with empty result buffer");

endmodule

bind heater_duty_and_valve_pulse_ctrl hdvp_checker u_hdvp_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_stall                (in_stall),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_heater_drive        (out_heater_drive),
  .out_valve_open_drive    (out_valve_open_drive),
  .out_valve_close_drive   (out_valve_close_drive),
  .out_temperature_reading (out_temperature_reading),
  .out_stale_count         (out_stale_count),
  .out_duty_phase          (out_duty_phase)
);
`default_nettype wire

@@ tb/heater_duty_and_valve_pulse_ctrl_tb.sv @@
// testbench for the heater duty and valve pulse controller: directed table, then random traffic
`timescale 1ns / 1ps
module heater_duty_and_valve_pulse_ctrl_tb;
  import hdvp_pkg::*;

  localparam int COARSE_PULSES = 100;
  localparam int FINE_PULSES   = 20;

  typedef enum logic [1:0] {ROW_ITEM, ROW_KNOWN, ROW_CFG} row_kind_t;
  typedef enum int {MIX_NORMAL, MIX_STALE, MIX_TICKS} mix_t;

  typedef struct packed {
    row_kind_t   kind;
    op_t         op;
    logic [7:0]  rd;
    logic        ovf;
    logic        dstb;
    logic [31:0] regs;  // duty low, duty high, zone, critical
    res_t        res;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_op;
  logic [7:0] in_reading;
  logic       in_reading_overflow;
  logic       in_reading_disturbed;
  logic       out_valid;
  logic       out_stall;
  logic       out_heater_drive;
  logic       out_valve_open_drive;
  logic       out_valve_close_drive;
  logic [7:0] out_temperature_reading;
  logic [7:0] out_stale_count;
  logic [7:0] out_duty_phase;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  // predictor copy of registers and state
  logic [7:0] r_duty_low, r_duty_high, r_zone, r_critical;
  logic [7:0] m_reading, m_stale, m_phase;
  logic       m_heater, m_open, m_close, m_pulse_on;
  logic [6:0] m_coarse;
  logic [4:0] m_fine;

  res_t     status_due[$];
  res_t     head_status;
  dir_row_t dir_rows[$];
  int       mismatches = 0;
  bit       no_idle = 1'b0;
  bit       hold_req = 1'b0;

  heater_duty_and_valve_pulse_ctrl dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_op                  (in_op),
    .in_reading             (in_reading),
    .in_reading_overflow    (in_reading_overflow),
    .in_reading_disturbed   (in_reading_disturbed),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_heater_drive       (out_heater_drive),
    .out_valve_open_drive   (out_valve_open_drive),
    .out_valve_close_drive  (out_valve_close_drive),
    .out_temperature_reading(out_temperature_reading),
    .out_stale_count        (out_stale_count),
    .out_duty_phase         (out_duty_phase),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    #2000000;
    $display("[heater_duty_and_valve_pulse_ctrl] ERROR");
    $finish;
  end

  task automatic thermostat_step(input op_t op, input logic [7:0] rd, input logic ovf,
                                 input logic dstb, output res_t r);
    logic [7:0] duty;
    case (op)
      OP_TICK: begin
        // decision uses the phase before it advances
        if (m_reading < MIN_VALID_READING || m_stale > STALE_LIMIT) begin
          m_heater = 1'b0;
        end else if (m_reading <= r_critical) begin
          m_heater = 1'b0;
        end else begin
          duty = (m_reading <= r_zone) ? r_duty_high : r_duty_low;
          m_heater = (duty == DUTY_ALWAYS) || (m_phase < duty);
        end
        m_phase = m_phase + 8'd1;
        if (m_pulse_on) begin
          if (m_fine == 5'd0) begin
            if (m_coarse == 7'd0) begin
              m_open = 1'b0;
              m_close = 1'b0;
              m_pulse_on = 1'b0;
            end else begin
              m_coarse = m_coarse - 7'd1;
              m_fine = 5'(FINE_PULSES);
            end
          end else begin
            m_fine = m_fine - 5'd1;
          end
        end
      end
      OP_MEASURE: begin
        if (dstb) begin
          if (m_stale < STALE_MAX) m_stale = m_stale + 8'd1;
        end else begin
          m_reading = ovf ? 8'hFF : rd;
          m_stale = 8'd0;
        end
      end
      default: begin
        m_open = (op == OP_VALVE_OPEN);
        m_close = (op != OP_VALVE_OPEN);
        m_coarse = 7'(COARSE_PULSES);
        m_fine = 5'(FINE_PULSES);
        m_pulse_on = 1'b1;
      end
    endcase
    r = {m_heater, m_open, m_close, m_reading, m_stale, m_phase};
  endtask

  // called at a rising edge; returns at the edge where the item was taken
  task automatic send_item(input op_t op, input logic [7:0] rd, input logic ovf,
                           input logic dstb, input bit known, input res_t known_res);
    int   gap;
    res_t r;
    gap = no_idle ? 0 : $urandom_range(11, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_reading <= rd;
    in_reading_overflow <= ovf;
    in_reading_disturbed <= dstb;
    do @(posedge clk); while (in_stall);
    thermostat_step(op, rd, ovf, dstb, r);
    status_due.push_back(known ? known_res : r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input reg_idx_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DUTY_LOW:  r_duty_low = val;
      REG_DUTY_HIGH: r_duty_high = val;
      REG_ZONE:      r_zone = val;
      default:       r_critical = val;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] dl, input logic [7:0] dh,
                              input logic [7:0] zl, input logic [7:0] cl);
    cfg_put(REG_DUTY_LOW, dl);
    cfg_put(REG_DUTY_HIGH, dh);
    cfg_put(REG_ZONE, zl);
    cfg_put(REG_CRITICAL, cl);
    cfg_valid <= 1'b0;
  endtask

  function automatic void tab_item(input op_t op, input logic [7:0] rd, input logic ovf,
                                   input logic dstb);
    dir_rows.push_back({ROW_ITEM, op, rd, ovf, dstb, 32'd0, res_t'('0)});
  endfunction

  function automatic void tab_known(input op_t op, input logic [7:0] rd, input logic ovf,
                                    input logic dstb, input logic h, input logic o,
                                    input logic c, input logic [7:0] t,
                                    input logic [7:0] s, input logic [7:0] p);
    res_t r;
    r = {h, o, c, t, s, p};
    dir_rows.push_back({ROW_KNOWN, op, rd, ovf, dstb, 32'd0, r});
  endfunction

  function automatic void tab_cfg(input logic [7:0] dl, input logic [7:0] dh,
                                  input logic [7:0] zl, input logic [7:0] cl);
    dir_rows.push_back({ROW_CFG, OP_TICK, 8'd0, 1'b0, 1'b0, {dl, dh, zl, cl}, res_t'('0)});
  endfunction

  task automatic run_random(input int n, input mix_t mix, input int hold_at,
                            input int pause_at);
    int         i, p, v;
    op_t        op;
    logic [7:0] rd;
    logic       ovf, dstb;
    for (i = 0; i < n; i++) begin
      no_idle = (i >= n / 4) && (i < n / 4 + 30);
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) wait_drained();
      case ($urandom_range(5, 0))
        0, 1: v = $urandom_range(255, 0);
        2: v = r_zone + $urandom_range(4, 0) - 2;
        3: v = r_critical + $urandom_range(4, 0) - 2;
        4: v = $urandom_range(17, 13);
        default: v = $urandom_range(1, 0) ? 255 : 0;
      endcase
      rd = v[7:0];
      ovf = 1'($urandom_range(1, 0));
      dstb = 1'($urandom_range(1, 0));
      p = $urandom_range(99, 0);
      case (mix)
        MIX_NORMAL: begin
          if (p < 60) op = OP_TICK;
          else if (p < 95) op = OP_MEASURE;
          else if (p < 97) op = OP_VALVE_OPEN;
          else op = OP_VALVE_CLOSE;
          if (op == OP_MEASURE) begin
            dstb = ($urandom_range(4, 0) == 0);
            ovf = ($urandom_range(6, 0) == 0);
          end
        end
        MIX_STALE: begin
          // long runs of disturbed measurements to saturate the stale count
          if (p < 30) op = OP_TICK;
          else if (p < 98) op = OP_MEASURE;
          else op = $urandom_range(1, 0) ? OP_VALVE_OPEN : OP_VALVE_CLOSE;
          if (op == OP_MEASURE) dstb = 1'b1;
        end
        default: begin
          // mostly ticks, so the valve pulse timer keeps counting down
          if (p < 97) op = OP_TICK;
          else op = OP_MEASURE;
          if (op == OP_MEASURE) begin
            dstb = 1'b0;
            ovf = ($urandom_range(6, 0) == 0);
          end
        end
      endcase
      send_item(op, rd, ovf, dstb, 1'b0, res_t'('0));
    end
    no_idle = 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        $error("unexpected result item");
        mismatches++;
      end else begin
        head_status = status_due.pop_front();
        check_field("heater_drive", head_status.heater_drive, out_heater_drive);
        check_field("valve_open_drive", head_status.valve_open_drive, out_valve_open_drive);
        check_field("valve_close_drive", head_status.valve_close_drive,
                    out_valve_close_drive);
        check_field("temperature_reading", head_status.temperature_reading,
                    out_temperature_reading);
        check_field("stale_count", head_status.stale_count, out_stale_count);
        check_field("duty_phase", head_status.duty_phase, out_duty_phase);
      end
    end
  end

  // result side: random stall per item, one long hold-off on request
  initial begin : result_sink
    int k;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        k = 200;
      end else begin
        k = no_idle ? 0 : $urandom_range(11, 0);
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    in_valid <= 1'b0;
    in_op <= OP_TICK;
    in_reading <= 8'd0;
    in_reading_overflow <= 1'b0;
    in_reading_disturbed <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DUTY_LOW;
    cfg_data <= 8'd0;
    rst_n <= 1'b0;
    r_duty_low = 8'd0;
    r_duty_high = 8'd0;
    r_zone = 8'd0;
    r_critical = 8'd0;
    m_reading = READING_RESET;
    m_stale = 8'd0;
    m_phase = 8'd0;
    m_heater = 1'b0;
    m_open = 1'b0;
    m_close = 1'b0;
    m_pulse_on = 1'b0;
    m_coarse = 7'(COARSE_PULSES);
    m_fine = 5'(FINE_PULSES);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset value: heater never on
    tab_known(OP_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255, 8'd0, 8'd1);
    tab_known(OP_MEASURE, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255, 8'd0, 8'd1);
    tab_known(OP_MEASURE, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd1);
    tab_known(OP_TICK, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd2);
    // overflow flag on a disturbed measurement is ignored
    tab_known(OP_MEASURE, 8'hAA, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 8'd1, 8'd2);
    tab_known(OP_VALVE_OPEN, 8'h55, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'd0, 8'd1, 8'd2);
    // valve item while a pulse runs
    tab_known(OP_VALVE_CLOSE, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 8'd1, 8'd2);
    tab_known(OP_MEASURE, MIN_VALID_READING, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd16, 8'd0,
              8'd2);
    tab_known(OP_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd16, 8'd0, 8'd3);
    tab_cfg(8'd255, 8'd0, 8'd128, 8'd32);
    tab_item(OP_MEASURE, 8'd200, 1'b0, 1'b0);
    tab_item(OP_TICK, 8'd0, 1'b0, 1'b0);
    tab_item(OP_MEASURE, 8'd100, 1'b0, 1'b0);
    tab_item(OP_TICK, 8'd0, 1'b0, 1'b0);
    tab_item(OP_MEASURE, 8'd32, 1'b0, 1'b0);
    tab_item(OP_TICK, 8'd0, 1'b0, 1'b0);
    tab_item(OP_MEASURE, 8'd33, 1'b0, 1'b0);
    tab_item(OP_TICK, 8'd0, 1'b0, 1'b0);
    tab_cfg(8'd0, 8'd255, 8'd255, 8'd15);
    tab_item(OP_MEASURE, 8'd16, 1'b0, 1'b0);
    tab_item(OP_TICK, 8'd0, 1'b0, 1'b0);
    tab_item(OP_MEASURE, 8'd0, 1'b1, 1'b0);
    tab_item(OP_TICK, 8'd0, 1'b0, 1'b0);
    tab_item(OP_MEASURE, 8'hFF, 1'b0, 1'b1);
    tab_item(OP_TICK, 8'd0, 1'b0, 1'b0);
    tab_cfg(8'd128, 8'd128, 8'd0, 8'd255);
    tab_item(OP_MEASURE, 8'd200, 1'b0, 1'b0);
    tab_item(OP_TICK, 8'd0, 1'b0, 1'b0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        program_regs(dir_rows[i].regs[31:24], dir_rows[i].regs[23:16],
                     dir_rows[i].regs[15:8], dir_rows[i].regs[7:0]);
      end else begin
        send_item(dir_rows[i].op, dir_rows[i].rd, dir_rows[i].ovf, dir_rows[i].dstb,
                  dir_rows[i].kind == ROW_KNOWN, dir_rows[i].res);
      end
    end

    wait_drained();
    program_regs(8'd255, 8'd255, 8'd255, 8'd255);
    run_random(120, MIX_NORMAL, -1, -1);

    wait_drained();
    program_regs(8'd0, 8'd0, 8'd0, 8'd0);
    run_random(100, MIX_NORMAL, -1, -1);

    // long receiver hold-off fills the result buffer and stalls the input
    wait_drained();
    program_regs(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
    run_random(200, MIX_NORMAL, 80, -1);

    wait_drained();
    program_regs(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)), 8'd200, 8'd40);
    run_random(460, MIX_STALE, -1, -1);

    // one valve pulse counting down over a long run of ticks
    wait_drained();
    program_regs(8'd255, 8'($urandom_range(254, 0)), 8'd128, 8'd20);
    send_item(OP_VALVE_OPEN, 8'($urandom_range(255, 0)), 1'b0, 1'b0, 1'b0, res_t'('0));
    run_random(550, MIX_TICKS, -1, -1);

    wait_drained();
    program_regs(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)), 8'($urandom_range(63, 0)));
    run_random(250, MIX_NORMAL, -1, 120);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("[heater_duty_and_valve_pulse_ctrl] OK");
    else $display("[heater_duty_and_valve_pulse_ctrl] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
design/hdvp_pkg.sv
design/hdvp_obuf.sv
design/heater_duty_and_valve_pulse_ctrl.sv
design/hdvp_checker.sv
tb/heater_duty_and_valve_pulse_ctrl_tb.sv
